// File: hw/rtl/fractal_escape_time_unit_macros.svh
// Assertion macros for the escape-time unit RTL.
// Files that check their own logic include this header; it depends on clk_i and rst_ni.
`ifndef FRACTAL_ESCAPE_TIME_UNIT_MACROS_SVH
`define FRACTAL_ESCAPE_TIME_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fet_pkg.sv
// Package for the escape-time fractal unit: types, register codes and fixed-point helpers.
// No dependencies; used by every module of the unit.
`default_nettype none

package fet_pkg;

  localparam int unsigned MaxIterDef     = 64;
  localparam int unsigned ImageWidthDef  = 1024;
  localparam int unsigned ImageHeightDef = 1024;

  localparam int unsigned PixW   = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CntOutW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;

  // Coordinate divider widths: magnitude of pixel offset, scaled numerator,
  // zoom times image size, and the kept quotient bits.
  localparam int unsigned MagW  = 12;
  localparam int unsigned NumW  = 14;
  localparam int unsigned DenW  = 45;
  localparam int unsigned QuoW  = 34;
  localparam int unsigned DivSteps = NumW + 52;

  typedef enum logic [1:0] {
    MODE_JULIA  = 2'd0,
    MODE_MANDEL = 2'd1,
    MODE_CUBIC  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE     = 3'd0,
    REG_ZOOM     = 3'd1,
    REG_OFF_RE   = 3'd2,
    REG_OFF_IM   = 3'd3,
    REG_C_RE     = 3'd4,
    REG_C_IM     = 3'd5,
    REG_START_RE = 3'd6,
    REG_START_IM = 3'd7
  } reg_idx_e;

  typedef struct packed {
    mode_e              mode;
    logic [DataW-1:0]   zoom;
    logic signed [DataW-1:0] off_re;
    logic signed [DataW-1:0] off_im;
    logic signed [DataW-1:0] c_re;
    logic signed [DataW-1:0] c_im;
    logic signed [DataW-1:0] start_re;
    logic signed [DataW-1:0] start_im;
  } cfg_t;

  // One classified pixel travelling from the front to the iteration engine.
  typedef struct packed {
    logic [PixW-1:0]         x;
    logic [PixW-1:0]         y;
    mode_e                   mode;
    logic signed [DataW-1:0] p_re;
    logic signed [DataW-1:0] p_im;
  } item_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return DataW'(hi);
    end else if (v < lo) begin
      return DataW'(lo);
    end
    return DataW'(v);
  endfunction

  // Raw product floored by 2^28 and saturated to Q4.28.
  function automatic logic signed [DataW-1:0] mulq(input logic signed [63:0] p);
    return sat32(p >>> 28);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fractal_escape_time_unit.sv
// Top level of the escape-time fractal unit: configuration registers and the three stages.
// Depends on fet_pkg, fet_front, fet_queue and fet_core.
`default_nettype none

// The unit takes one pixel beat (pixel_x_i, pixel_y_i) through push/full and returns one
// result beat (out_x_o, out_y_o, iteration_count_o) through empty/pop, in input order. The
// front end maps the pixel to a Q4.28 complex point with two bit-serial restoring dividers
// that run side by side, then hands the point to the queue; full stays high until the
// point has entered the queue, so the front end takes no new pixel before then. A
// two-entry queue lets the front end map the next pixel while the iteration engine works.
// Each pass of the engine has a step for the registered squares and a step for the update
// and escape test; cubic Julia mode adds a step for the registered cubic products between
// the two. A pixel that escapes after n counted iterations takes n + 2 passes, and one that
// never escapes takes MAX_ITER + 1; on top come a load step and a step that hands the
// result to the output register. A result waiting in the output register does not
// stop the engine from starting the next pixel. Registers are written through
// cfg_valid_i/cfg_ready_o, which is always ready; they must only be changed while no
// pixel is in flight.

module fractal_escape_time_unit
  import fet_pkg::*;
#(
  parameter int unsigned MAX_ITER     = MaxIterDef,
  parameter int unsigned IMAGE_WIDTH  = ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [PixW-1:0]    pixel_x_i,
  input  logic [PixW-1:0]    pixel_y_i,
  output logic               empty,
  input  logic               pop,
  output logic [PixW-1:0]    out_x_o,
  output logic [PixW-1:0]    out_y_o,
  output logic [CntOutW-1:0] iteration_count_o
);

  cfg_t  cfg_q;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_JULIA;
      cfg_q.zoom     <= 32'h0100_0000;
      cfg_q.off_re   <= '0;
      cfg_q.off_im   <= '0;
      cfg_q.c_re     <= '0;
      cfg_q.c_im     <= '0;
      cfg_q.start_re <= '0;
      cfg_q.start_im <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:     cfg_q.mode     <= mode_e'(cfg_data_i[1:0]);
        REG_ZOOM:     cfg_q.zoom     <= cfg_data_i;
        REG_OFF_RE:   cfg_q.off_re   <= cfg_data_i;
        REG_OFF_IM:   cfg_q.off_im   <= cfg_data_i;
        REG_C_RE:     cfg_q.c_re     <= cfg_data_i;
        REG_C_IM:     cfg_q.c_im     <= cfg_data_i;
        REG_START_RE: cfg_q.start_re <= cfg_data_i;
        REG_START_IM: cfg_q.start_im <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fet_front #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push     (push),
    .full     (full),
    .pixel_x_i(pixel_x_i),
    .pixel_y_i(pixel_y_i),
    .q_push_o (q_push),
    .q_item_o (q_in),
    .q_full_i (q_full)
  );

  fet_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .item_o (q_out),
    .empty_o(q_empty)
  );

  fet_core #(
    .MAX_ITER(MAX_ITER)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_i           (q_out),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .iteration_count_o(iteration_count_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/fet_front.sv
// Front end: takes pixel beats and maps them to complex points with two bit-serial dividers.
// Depends on fet_pkg.
`default_nettype none

module fet_front
  import fet_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            push,
  output logic            full,
  input  logic [PixW-1:0] pixel_x_i,
  input  logic [PixW-1:0] pixel_y_i,
  output logic            q_push_o,
  output item_t           q_item_o,
  input  logic            q_full_i
);

  localparam int unsigned StepW = $clog2(DivSteps + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e                 state_q;
  logic [StepW-1:0]       step_q;
  logic [PixW-1:0]        x_q, y_q;
  mode_e                  mode_q;
  logic [NumW-1:0]        num_q [2];
  logic [DenW-1:0]        den_q [2];
  logic [DenW:0]          rem_q [2];
  logic [QuoW-1:0]        quo_q [2];
  logic                   ovf_q [2];
  logic                   neg_q [2];

  logic signed [13:0]     dx, dy;
  logic [MagW-1:0]        mx, my;
  logic [DataW-1:0]       zoom_eff;
  logic [DenW:0]          rem_sh [2];
  logic                   ge [2];
  logic signed [DataW-1:0] coord [2];
  logic signed [DataW-1:0] off [2];

  assign dx = 14'(pixel_x_i) - 14'(IMAGE_WIDTH / 2);
  assign dy = 14'(pixel_y_i) - 14'(IMAGE_HEIGHT / 2);
  assign mx = dx[13] ? MagW'(-dx) : MagW'(dx);
  assign my = dy[13] ? MagW'(-dy) : MagW'(dy);
  assign zoom_eff = (cfg_i.zoom == '0) ? DataW'(1) : cfg_i.zoom;
  assign off[0] = cfg_i.off_re;
  assign off[1] = cfg_i.off_im;

  always_comb begin
    logic [QuoW-1:0]     qm;
    logic signed [63:0]  sv;
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l][DenW-1:0], num_q[l][NumW-1]};
      ge[l]     = rem_sh[l] >= {1'b0, den_q[l]};
      qm        = ovf_q[l] ? '1 : quo_q[l];
      sv        = $signed({30'd0, qm});
      if (neg_q[l]) begin
        sv = -sv;
      end
      coord[l]  = sat32(sv + 64'(off[l]));
    end
  end

  assign full     = (state_q != ST_IDLE);
  assign q_push_o = (state_q == ST_PUSH) && !q_full_i;
  assign q_item_o = '{x: x_q, y: y_q, mode: mode_q, p_re: coord[0], p_im: coord[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (push) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end
        end
        ST_DIV: begin
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= ST_PUSH;
          end
          step_q <= step_q + 1'b1;
        end
        ST_PUSH: begin
          if (!q_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: restoring division of num * 2^52 by zoom * size, one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && push) begin
      x_q      <= pixel_x_i;
      y_q      <= pixel_y_i;
      mode_q   <= cfg_i.mode;
      num_q[0] <= NumW'({mx, 1'b0}) + NumW'(mx);
      num_q[1] <= NumW'({my, 1'b0});
      den_q[0] <= DenW'(zoom_eff) * DenW'(IMAGE_WIDTH);
      den_q[1] <= DenW'(zoom_eff) * DenW'(IMAGE_HEIGHT);
      neg_q[0] <= dx[13];
      neg_q[1] <= dy[13];
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
        ovf_q[l] <= 1'b0;
      end
    end else if (state_q == ST_DIV) begin
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= {num_q[l][NumW-2:0], 1'b0};
        rem_q[l] <= ge[l] ? (rem_sh[l] - {1'b0, den_q[l]}) : rem_sh[l];
        quo_q[l] <= {quo_q[l][QuoW-2:0], ge[l]};
        ovf_q[l] <= ovf_q[l] | quo_q[l][QuoW-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fet_queue.sv
// Short queue of classified pixels between the front end and the iteration engine.
// Depends on fet_pkg.
`default_nettype none

module fet_queue
  import fet_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned AW = (QDepth > 1) ? $clog2(QDepth) : 1;

  item_t         mem_q [QDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fet_core.sv
// Iteration engine: runs the escape-time loop for one point and holds the result beat.
// Depends on fet_pkg and the unit's assertion macros.
`default_nettype none
`include "fractal_escape_time_unit_macros.svh"

module fet_core
  import fet_pkg::*;
#(
  parameter int unsigned MAX_ITER = MaxIterDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  item_t              item_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [PixW-1:0]    out_x_o,
  output logic [PixW-1:0]    out_y_o,
  output logic [CntOutW-1:0] iteration_count_o
);

  localparam int unsigned CntW = $clog2(MAX_ITER + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_CUBE,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e                  state_q;
  mode_e                   mode_q;
  logic                    started_q;
  logic [CntW-1:0]         cnt_q;
  logic [PixW-1:0]         x_q, y_q;
  logic signed [DataW-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [63:0]      rr_q, ii_q, ri_q;
  logic signed [63:0]      k3r_q, k3i_q, kri2_q, kr2i_q;
  logic                    res_vld_q;
  logic [PixW-1:0]         res_x_q, res_y_q;
  logic [CntW-1:0]         res_cnt_q;

  logic signed [DataW-1:0] r2, i2;
  logic signed [63:0]      r2w, i2w, mag2, nr_w, ni_w;
  logic                    esc;
  logic [CntW-1:0]         cnt_inc;
  logic signed [DataW-1:0] nr, ni;
  logic                    load_res;

  assign r2   = mulq(rr_q);
  assign i2   = mulq(ii_q);
  assign r2w  = 64'(r2);
  assign i2w  = 64'(i2);
  assign mag2 = r2w + i2w;
  assign esc  = mag2 > 64'sh0000_0000_4000_0000;
  assign cnt_inc = cnt_q + 1'b1;

  // The finished pixel moves to the output register once that register is free or being read.
  assign load_res = (state_q == ST_DONE) && (!res_vld_q || pop);

  always_comb begin
    logic signed [63:0] r3w, i3w, ri2w, r2iw;
    r3w  = 64'(mulq(k3r_q));
    i3w  = 64'(mulq(k3i_q));
    ri2w = 64'(mulq(kri2_q));
    r2iw = 64'(mulq(kr2i_q));
    if (mode_q == MODE_CUBIC) begin
      nr_w = r3w - 64'sd3 * ri2w + 64'(cr_q);
      ni_w = 64'sd3 * r2iw - i3w + 64'(ci_q);
    end else begin
      nr_w = r2w - i2w + 64'(cr_q);
      ni_w = 64'(sat32(ri_q >>> 27)) + 64'(ci_q);
    end
    nr = sat32(nr_w);
    ni = sat32(ni_w);
  end

  assign q_pop_o           = (state_q == ST_IDLE) && !q_empty_i;
  assign empty             = !res_vld_q;
  assign out_x_o           = res_x_q;
  assign out_y_o           = res_y_q;
  assign iteration_count_o = CntOutW'(res_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= load_res || (res_vld_q && !pop);
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            started_q <= 1'b0;
            cnt_q     <= '0;
            state_q   <= (item_i.mode == MODE_NONE) ? ST_DONE : ST_SQR;
          end
        end
        ST_SQR: begin
          state_q <= (mode_q == MODE_CUBIC) ? ST_CUBE : ST_UPD;
        end
        ST_CUBE: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (started_q && esc) begin
            state_q <= ST_DONE;
          end else if (started_q && cnt_inc == CntW'(MAX_ITER)) begin
            cnt_q   <= cnt_inc;
            state_q <= ST_DONE;
          end else begin
            if (started_q) begin
              cnt_q <= cnt_inc;
            end
            started_q <= 1'b1;
            state_q   <= ST_SQR;
          end
        end
        ST_DONE: begin
          if (load_res) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !q_empty_i) begin
      x_q    <= item_i.x;
      y_q    <= item_i.y;
      mode_q <= item_i.mode;
      if (item_i.mode == MODE_MANDEL) begin
        zr_q <= cfg_i.start_re;
        zi_q <= cfg_i.start_im;
        cr_q <= item_i.p_re;
        ci_q <= item_i.p_im;
      end else begin
        zr_q <= item_i.p_re;
        zi_q <= item_i.p_im;
        cr_q <= cfg_i.c_re;
        ci_q <= cfg_i.c_im;
      end
    end
    if (state_q == ST_SQR) begin
      rr_q <= 64'(zr_q) * 64'(zr_q);
      ii_q <= 64'(zi_q) * 64'(zi_q);
      ri_q <= 64'(zr_q) * 64'(zi_q);
    end
    if (state_q == ST_CUBE) begin
      k3r_q  <= 64'(r2) * 64'(zr_q);
      k3i_q  <= 64'(i2) * 64'(zi_q);
      kri2_q <= 64'(zr_q) * 64'(i2);
      kr2i_q <= 64'(r2) * 64'(zi_q);
    end
    if (state_q == ST_UPD && !(started_q && esc)) begin
      zr_q <= nr;
      zi_q <= ni;
    end
    if (load_res) begin
      res_x_q   <= x_q;
      res_y_q   <= y_q;
      res_cnt_q <= cnt_q;
    end
  end

  `FET_ASSERT_IMP(a_cnt_range, state_q != ST_IDLE, cnt_q <= CntW'(MAX_ITER), "count past maximum")
  `FET_ASSERT_NXT(a_done_waits, state_q == ST_DONE && res_vld_q && !pop, state_q == ST_DONE, "result overwritten")
  `FET_ASSERT_IMP(a_unused_zero, state_q == ST_DONE && mode_q == MODE_NONE, cnt_q == '0, "unused mode iterated")
  `FET_ASSERT_IMP(a_pop_idle, q_pop_o, state_q == ST_IDLE, "queue read while busy")

endmodule

`default_nettype wire

// File: verif/fractal_escape_time_checker.sv
// Checker for the escape-time fractal unit: predicts the iteration count of each pixel beat.
// Depends on fet_pkg; watches the pixel, result and register channels of the unit.
`timescale 1ns / 1ps

module fractal_escape_time_checker
  import fet_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [PixW-1:0]    pixel_x_i,
  input  logic [PixW-1:0]    pixel_y_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [PixW-1:0]    out_x_i,
  input  logic [PixW-1:0]    out_y_i,
  input  logic [CntOutW-1:0] iteration_count_i,
  output int                 pending_o,
  output int                 errors_o
);

  typedef struct packed {
    logic [PixW-1:0]    x;
    logic [PixW-1:0]    y;
    logic [CntOutW-1:0] count;
  } pixel_result_t;

  localparam longint Limit4 = 64'sd4 <<< 28;

  cfg_t          regs;
  pixel_result_t want_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product floored by 2^n, then clamped.
  function automatic longint fmul(input longint a, input longint b, input int n);
    return clamp32((a * b) >>> n);
  endfunction

  function automatic longint pixel_to_point(input int pix, input int size, input int factor,
                                            input logic signed [DataW-1:0] offset);
    int          d;
    logic [12:0] mag;
    logic [127:0] num;
    logic [127:0] den;
    longint       q;
    d   = pix - size / 2;
    mag = 13'((d < 0) ? -d : d);
    num = 128'(factor * mag) << 52;
    den = 128'((regs.zoom != 0) ? regs.zoom : 32'd1) * 128'(size);
    q   = longint'(num / den);
    if (d < 0) q = -q;
    return clamp32(q + longint'(offset));
  endfunction

  function automatic logic [CntOutW-1:0] escape_count(input logic [PixW-1:0] px,
                                                      input logic [PixW-1:0] py);
    longint pr, pi, zr, zi, cr, ci, r2, i2, nr, ni;
    int     n;
    pr = pixel_to_point(px, ImageWidthDef, 3, regs.off_re);
    pi = pixel_to_point(py, ImageHeightDef, 2, regs.off_im);
    n  = 0;
    if (regs.mode == MODE_MANDEL) begin
      zr = regs.start_re; zi = regs.start_im; cr = pr; ci = pi;
    end else begin
      zr = pr; zi = pi; cr = regs.c_re; ci = regs.c_im;
    end
    if (regs.mode == MODE_NONE) return '0;
    while (n < MaxIterDef) begin
      r2 = fmul(zr, zr, 28);
      i2 = fmul(zi, zi, 28);
      if (regs.mode == MODE_CUBIC) begin
        nr = clamp32(fmul(r2, zr, 28) - 3 * fmul(zr, i2, 28) + cr);
        ni = clamp32(3 * fmul(r2, zi, 28) - fmul(i2, zi, 28) + ci);
      end else begin
        nr = clamp32(r2 - i2 + cr);
        ni = clamp32(fmul(zr, zi, 27) + ci);
      end
      zr = nr;
      zi = ni;
      if (fmul(zr, zr, 28) + fmul(zi, zi, 28) > Limit4) break;
      n++;
    end
    return CntOutW'(n);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      regs          <= '{mode: MODE_JULIA, zoom: 32'h0100_0000, off_re: '0, off_im: '0,
                         c_re: '0, c_im: '0, start_re: '0, start_im: '0};
      errors_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MODE:     regs.mode     <= mode_e'(cfg_data_i[1:0]);
          REG_ZOOM:     regs.zoom     <= cfg_data_i;
          REG_OFF_RE:   regs.off_re   <= cfg_data_i;
          REG_OFF_IM:   regs.off_im   <= cfg_data_i;
          REG_C_RE:     regs.c_re     <= cfg_data_i;
          REG_C_IM:     regs.c_im     <= cfg_data_i;
          REG_START_RE: regs.start_re <= cfg_data_i;
          REG_START_IM: regs.start_im <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        want_q.push_back('{pixel_x_i, pixel_y_i, escape_count(pixel_x_i, pixel_y_i)});
      end
      if (pop_i && !empty_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: x=%0d y=%0d count=%0d", $time,
                   out_x_i, out_y_i, iteration_count_i);
          errors_o <= errors_o + 1;
        end else begin
          want = want_q.pop_front();
          if (want != {out_x_i, out_y_i, iteration_count_i}) begin
            $display("%0t: mismatch expected x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
                     $time, want.x, want.y, want.count, out_x_i, out_y_i, iteration_count_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = want_q.size();

endmodule

// File: verif/fractal_escape_time_unit_test.sv
// Top of the escape-time fractal unit testbench: clock, reset, stimulus and the verdict.
// Depends on fet_pkg, fractal_escape_time_unit and fractal_escape_time_checker.
`timescale 1ns / 1ps

module fractal_escape_time_unit_test;
  import fet_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]   cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [PixW-1:0]    pixel_x_i = '0;
  logic [PixW-1:0]    pixel_y_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [PixW-1:0]    out_x_o;
  logic [PixW-1:0]    out_y_o;
  logic [CntOutW-1:0] iteration_count_o;
  int                 pending;
  int                 errors;

  // When set, the result side stops popping; the hold-off is counted in its own process.
  bit                 hold_results = 1'b0;

  always #5 clk_i = ~clk_i;

  fractal_escape_time_unit uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .pixel_x_i, .pixel_y_i, .empty, .pop,
    .out_x_o, .out_y_o, .iteration_count_o
  );

  fractal_escape_time_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .push_i(push), .full_i(full), .pixel_x_i, .pixel_y_i, .empty_i(empty), .pop_i(pop),
    .out_x_i(out_x_o), .out_y_i(out_y_o), .iteration_count_i(iteration_count_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Most gaps are short; about one in ten is long.
  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(200, 20);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(4);
  endfunction

  // One register beat, driven at the falling edge and held until it is taken.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One pixel beat; the optional gap comes after the handshake so push stays high
  // across back-to-back beats.
  task automatic send_pixel(input logic [PixW-1:0] x, input logic [PixW-1:0] y,
                            input bit gaps);
    int g;
    push      <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // The block is idle once nothing is expected; the engine latency is already covered
  // since every pixel gives exactly one result.
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_view();
    logic [DataW-1:0] v;
    v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0400_0000, 32'h0080_0000);
    write_reg(REG_ZOOM, v);
    write_reg(REG_OFF_RE, $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(
              32'h1000_0000)) - 32'sh0800_0000);
    write_reg(REG_OFF_IM, $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(
              32'h1000_0000)) - 32'sh0800_0000);
    write_reg(REG_C_RE, $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(
              32'h2000_0000)) - 32'sh1000_0000);
    write_reg(REG_C_IM, $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(
              32'h2000_0000)) - 32'sh1000_0000);
    write_reg(REG_START_RE, $urandom_range(1) ? 32'h0 : $urandom());
    write_reg(REG_START_IM, $urandom_range(1) ? 32'h0 : $urandom());
  endtask

  // Result side: random pop gaps, plus a long hold-off when requested.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        pop <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_results = 1'b0;
      end else if ($urandom_range(4) == 0) begin
        g = gap_len();
        pop <= 1'b0;
        repeat (g) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners at reset settings: field extremes, center and edges.
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd512, 10'd512, 0);
    send_pixel(10'd0, 10'd1023, 0);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'h2AA, 10'h155, 0);
    drain();

    // Mandelbrot with default start, including a point that never escapes.
    write_reg(REG_MODE, DataW'(MODE_MANDEL));
    send_pixel(10'd400, 10'd512, 0);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd255, 10'd700, 0);
    drain();

    // Cubic Julia with a small constant.
    write_reg(REG_MODE, DataW'(MODE_CUBIC));
    write_reg(REG_C_RE, 32'h0800_0000);
    write_reg(REG_C_IM, 32'hF800_0000);
    send_pixel(10'd512, 10'd512, 0);
    send_pixel(10'd600, 10'd300, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    drain();

    // Unused mode gives a zero count.
    write_reg(REG_MODE, DataW'(MODE_NONE));
    send_pixel(10'd100, 10'd900, 0);
    drain();

    // Zoom of zero, the largest zoom and a zoom of one; extreme offsets saturate the point.
    write_reg(REG_MODE, DataW'(MODE_JULIA));
    write_reg(REG_ZOOM, 32'h0);
    write_reg(REG_OFF_RE, 32'h7FFF_FFFF);
    write_reg(REG_OFF_IM, 32'h8000_0000);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'd0, 10'd1023, 0);
    drain();
    write_reg(REG_ZOOM, 32'hFFFF_FFFF);
    write_reg(REG_OFF_RE, 32'h0);
    write_reg(REG_OFF_IM, 32'h0);
    write_reg(REG_START_RE, 32'h7FFF_FFFF);
    write_reg(REG_START_IM, 32'h8000_0000);
    send_pixel(10'd513, 10'd511, 0);
    drain();
    write_reg(REG_ZOOM, 32'h0000_0001);
    send_pixel(10'd513, 10'd511, 0);
    drain();

    // Random phases: each phase picks a view, then a burst of pixels.
    for (i = 0; i < 12; i++) begin
      write_reg(REG_MODE, DataW'(($urandom_range(7) == 0) ? MODE_NONE
                                 : mode_e'($urandom_range(2))));
      random_view();
      // In one phase the result side stalls for long while pixels keep coming.
      if (i == 3) hold_results = 1'b1;
      repeat (36) send_pixel(PixW'($urandom_range(1023)), PixW'($urandom_range(1023)), 1);
      // The sender waits for every result before the next phase.
      drain();
    end

    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("fractal_escape_time_unit test passed");
    end else begin
      $display("fractal_escape_time_unit test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("fractal_escape_time_unit test failed");
    $finish;
  end

endmodule
